@@ hdl/brb_pkg.sv @@
// Shared types, sizes and GF(2^8) arithmetic for the batch recoding buffer.
// Used by brb_gf_mac and batch_recoding_buffer_gf256; no dependencies.
package brb_pkg;

    localparam int SLOTS   = 8;
    localparam int SYMBOLS = 1024;
    localparam int SLOT_W  = $clog2(SLOTS);
    localparam int CNT_W   = $clog2(SLOTS + 1);
    localparam int ADDR_W  = $clog2(SLOTS * SYMBOLS);
    localparam int DEPTH   = SLOTS * SYMBOLS;

    localparam logic [8:0] POLY_RESET = 9'h11D;

    localparam logic ACT_STORE  = 1'b0;
    localparam logic ACT_RECODE = 1'b1;

    typedef struct packed {
        logic        action;
        logic [15:0] batch_id;
        logic        packet_start;
        logic [9:0]  symbol_index;
        logic [7:0]  symbol_value;
        logic [63:0] coefficients;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  recoded_symbol;
        logic [15:0] out_batch_id;
        logic [3:0]  packets_combined;
        logic        no_batch;
    } t_out_item;

    typedef struct packed {
        logic clr;
        logic en;
    } t_mac_ctl;

    function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] pos);
        logic [SLOT_W-1:0] nxt;
        if (pos == SLOT_W'(SLOTS - 1)) begin
            nxt = '0;
        end else begin
            nxt = pos + 1'b1;
        end
        return nxt;
    endfunction

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b,
                                          input logic [7:0] taps);
        logic [7:0] x;
        logic [7:0] acc;
        x   = a;
        acc = '0;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) begin
                acc = acc ^ x;
            end
            x = x[7] ? ({x[6:0], 1'b0} ^ taps) : {x[6:0], 1'b0};
        end
        return acc;
    endfunction

endpackage

@@ hdl/batch_recoding_buffer_gf256.sv @@
// Top level of the GF(2^8) batch recoding buffer: slot ring, symbol memory, walk sequencer.
// Depends on brb_pkg and brb_gf_mac.
//
//  channel | direction | handshake                | payload
//  in      | input     | i_in_valid / o_in_stall  | i_in_item  (brb_pkg::t_in_item)
//  out     | output    | o_out_valid / i_out_stall| o_out_item (brb_pkg::t_out_item)
//  cfg     | input     | i_cfg_we                 | i_cfg_data (field polynomial)
//
// A store item does not stall the input. A recode item that combines k slots stalls the
// input while it walks the slots and emits its result, at one slot per cycle,
// set by the single memory read port and the shared multiply-accumulate unit;
// its result is registered when the recode leaves the emit state.
// Reset is synchronous; the symbol memory is not cleared.
// A result held by i_out_stall blocks only the next recode, in its emit state.
module batch_recoding_buffer_gf256 (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  brb_pkg::t_in_item   i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output brb_pkg::t_out_item  o_out_item,
    input  logic                i_cfg_we,
    input  logic [8:0]          i_cfg_data
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_WALK = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    localparam logic [7:0] POLY_TAPS_RESET = brb_pkg::POLY_RESET[7:0];

    logic [1:0]                 r_state, n_state;
    logic [7:0]                 r_taps;
    logic [brb_pkg::SLOT_W-1:0] r_head, n_head;
    logic [brb_pkg::SLOT_W-1:0] r_tail, n_tail;
    logic [brb_pkg::SLOT_W-1:0] r_pos, n_pos;
    logic [brb_pkg::CNT_W-1:0]  r_k, n_k;
    logic [15:0]                r_cur, n_cur;
    logic                       r_have, n_have;
    logic                       r_pend, n_pend;
    logic                       r_out_valid, n_out_valid;
    logic [brb_pkg::SLOTS-1:0]  r_slot_valid;
    logic [15:0]                r_slot_batch [brb_pkg::SLOTS];
    logic [9:0]                 r_idx;
    logic                       r_idx_ok;
    logic                       r_no_batch;
    logic [63:0]                r_coefs;
    logic [7:0]                 r_coef_q;
    logic [7:0]                 r_rdata;
    logic [7:0]                 r_mem [brb_pkg::DEPTH];
    brb_pkg::t_out_item         r_out;

    logic                       w_accept;
    logic                       w_store;
    logic                       w_start;
    logic                       w_flush;
    logic                       w_full;
    logic                       w_idx_ok;
    logic                       w_we;
    logic                       w_slot_ok;
    logic                       w_issue;
    logic                       w_emit;
    logic [brb_pkg::SLOT_W-1:0] w_tail_inc;
    logic [brb_pkg::SLOT_W-1:0] w_store_slot;
    logic [brb_pkg::ADDR_W-1:0] w_waddr;
    logic [brb_pkg::ADDR_W-1:0] w_raddr;
    logic [7:0]                 w_acc;
    brb_pkg::t_mac_ctl          w_mac_ctl;

    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_store    = w_accept && (i_in_item.action == brb_pkg::ACT_STORE);
    assign w_start    = i_in_item.packet_start;
    assign w_flush    = !r_have || (i_in_item.batch_id != r_cur);
    assign w_tail_inc = brb_pkg::slot_inc(r_tail);
    assign w_full     = (w_tail_inc == r_head);
    assign w_idx_ok   = int'(i_in_item.symbol_index) < brb_pkg::SYMBOLS;

    always_comb begin
        if (!w_start) begin
            w_store_slot = r_tail;
        end else if (w_flush) begin
            w_store_slot = '0;
        end else if (w_full) begin
            w_store_slot = r_head;
        end else begin
            w_store_slot = w_tail_inc;
        end
    end

    assign w_we    = w_store && (w_start || r_have) && w_idx_ok;
    assign w_waddr = brb_pkg::ADDR_W'(w_store_slot) * brb_pkg::ADDR_W'(brb_pkg::SYMBOLS)
                   + brb_pkg::ADDR_W'(i_in_item.symbol_index);
    assign w_raddr = brb_pkg::ADDR_W'(r_pos) * brb_pkg::ADDR_W'(brb_pkg::SYMBOLS)
                   + brb_pkg::ADDR_W'(r_idx);

    assign w_slot_ok = r_have && r_slot_valid[r_pos] && (r_slot_batch[r_pos] == r_cur);
    assign w_issue   = (r_state == S_WALK) && (r_k != brb_pkg::CNT_W'(brb_pkg::SLOTS))
                     && w_slot_ok;
    assign w_emit    = (r_state == S_EMIT) && (!r_out_valid || !i_out_stall);

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_tail      = r_tail;
        n_pos       = r_pos;
        n_k         = r_k;
        n_cur       = r_cur;
        n_have      = r_have;
        n_pend      = 1'b0;
        n_out_valid = r_out_valid && i_out_stall;
        case (r_state)
            S_IDLE: begin
                if (w_store && w_start) begin
                    if (w_flush) begin
                        n_have = 1'b1;
                        n_cur  = i_in_item.batch_id;
                        n_head = '0;
                    end else if (w_full) begin
                        n_head = brb_pkg::slot_inc(r_head);
                    end
                    n_tail = w_store_slot;
                end else if (w_accept && (i_in_item.action == brb_pkg::ACT_RECODE)) begin
                    n_state = S_WALK;
                    n_pos   = r_head;
                    n_k     = '0;
                end
            end
            S_WALK: begin
                if (w_issue) begin
                    n_pend = 1'b1;
                    n_pos  = brb_pkg::slot_inc(r_pos);
                    n_k    = r_k + 1'b1;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (w_emit) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_taps       <= POLY_TAPS_RESET;
            r_head       <= '0;
            r_tail       <= '0;
            r_pos        <= '0;
            r_k          <= '0;
            r_cur        <= '0;
            r_have       <= 1'b0;
            r_pend       <= 1'b0;
            r_out_valid  <= 1'b0;
            r_slot_valid <= '0;
            for (int i = 0; i < brb_pkg::SLOTS; i++) begin
                r_slot_batch[i] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_pos       <= n_pos;
            r_k         <= n_k;
            r_cur       <= n_cur;
            r_have      <= n_have;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_taps <= i_cfg_data[7:0];
            end
            if (w_store && w_start) begin
                r_slot_valid[w_store_slot] <= 1'b1;
                r_slot_batch[w_store_slot] <= i_in_item.batch_id;
            end
        end
    end

    // hold the recode request for the walk, pick each slot's coefficient and register the result
    always_ff @(posedge i_clk) begin
        if (w_accept && (i_in_item.action == brb_pkg::ACT_RECODE)) begin
            r_idx      <= i_in_item.symbol_index;
            r_idx_ok   <= w_idx_ok;
            r_no_batch <= !r_have;
            r_coefs    <= i_in_item.coefficients;
        end
        if (w_issue) begin
            r_coef_q <= r_coefs[8*r_k[brb_pkg::SLOT_W-1:0] +: 8];
        end
        if (w_emit) begin
            r_out.recoded_symbol   <= r_no_batch ? 8'd0 : w_acc;
            r_out.out_batch_id     <= r_no_batch ? 16'd0 : r_cur;
            r_out.packets_combined <= 4'(r_k);
            r_out.no_batch         <= r_no_batch;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= i_in_item.symbol_value;
        end
        if (w_issue) begin
            r_rdata <= r_mem[w_raddr];
        end
    end

    assign w_mac_ctl.clr = w_accept && (i_in_item.action == brb_pkg::ACT_RECODE);
    assign w_mac_ctl.en  = r_pend && r_idx_ok;

    brb_gf_mac u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_mac_ctl),
        .i_coef   (r_coef_q),
        .i_symbol (r_rdata),
        .i_taps   (r_taps),
        .o_acc    (w_acc)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_k <= brb_pkg::CNT_W'(brb_pkg::SLOTS))
        else $error("walk count beyond slot count");

    a_recode_walks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_in_item.action == brb_pkg::ACT_RECODE) |=> (r_state == S_WALK))
        else $error("recode item did not start a walk");

    a_head_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_have |-> r_slot_valid[r_head])
        else $error("head slot not valid while a batch is buffered");

    a_pend_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> (r_state == S_WALK || r_state == S_EMIT))
        else $error("pending product outside a walk");

    a_no_batch_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.no_batch) |->
        (o_out_item.recoded_symbol == 8'd0 && o_out_item.packets_combined == 4'd0))
        else $error("empty buffer result carries data");

endmodule

@@ hdl/brb_gf_mac.sv @@
// GF(2^8) multiply-accumulate unit shared by every slot of a recode walk.
// Depends on brb_pkg for gf_mul and the control struct.
module brb_gf_mac (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  brb_pkg::t_mac_ctl i_ctl,
    input  logic [7:0]      i_coef,
    input  logic [7:0]      i_symbol,
    input  logic [7:0]      i_taps,
    output logic [7:0]      o_acc
);

    logic [7:0] r_acc;
    logic [7:0] n_acc;

    always_comb begin
        n_acc = r_acc;
        if (i_ctl.clr) begin
            n_acc = '0;
        end else if (i_ctl.en) begin
            n_acc = r_acc ^ brb_pkg::gf_mul(i_coef, i_symbol, i_taps);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else begin
            r_acc <= n_acc;
        end
    end

    assign o_acc = r_acc;

endmodule
